### src/lcdns_pkg.sv
package lcdns_pkg;

    typedef struct packed {
        logic       is_data;
        logic [7:0] byte_value;
    } t_in_item;

    typedef struct packed {
        logic       rs_level;
        logic [3:0] data_nibble;
        logic       enable_level;
        logic [9:0] duration_ms;
        logic       last_segment;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PWR,
        S_WAKE,
        S_INIT,
        S_USER
    } t_state;

    typedef enum logic [1:0] {
        SRC_PWR,
        SRC_WAKE,
        SRC_INIT,
        SRC_USER
    } t_src;

    typedef struct packed {
        logic       accept;
        logic       load;
        t_src       src;
        logic [1:0] idx;
        logic [1:0] seg;
        logic       last;
    } t_seg_cmd;

    typedef struct packed {
        logic out_free;
        logic lcd_ready;
    } t_dp_status;

    localparam logic [2:0] CFG_POWER_UP    = 3'd0;
    localparam logic [2:0] CFG_ENABLE_HIGH = 3'd1;
    localparam logic [2:0] CFG_SETTLE      = 3'd2;
    localparam logic [2:0] CFG_CLEAR_WAIT  = 3'd3;
    localparam logic [2:0] CFG_WAKE_WAIT   = 3'd4;
    localparam logic [2:0] CFG_FUNC_SET    = 3'd5;
    localparam logic [2:0] CFG_DISPLAY     = 3'd6;
    localparam logic [2:0] CFG_ENTRY_MODE  = 3'd7;

    localparam logic [7:0] CLEAR_CMD       = 8'h01;
    localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
    localparam logic [3:0] WAKE_LAST_NIB   = 4'h2;
    localparam logic [7:0] WAKE_THIRD_MS   = 8'd1;
    localparam logic [1:0] LAST_IDX        = 2'd3;
    localparam logic [1:0] LAST_SEG        = 2'd3;

endpackage

### src/char_lcd_nibble_sequencer.sv
// 4-bit character LCD sequencer: each accepted item (command or data byte) becomes
// four pin segments (enable high, enable low, for the high then the low nibble), each
// with a hold time in ms for a timing back end; last_segment marks the final one. The
// first item after reset is preceded by the power-up wait, the wake-up nibbles, the
// set-up commands and a clear, 25 segments in all. The controller emits one segment
// per cycle into a single output register, unless the output stalls; a new item is
// taken once the previous one is fully emitted.
module char_lcd_nibble_sequencer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  lcdns_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output lcdns_pkg::t_out_item o_out_item,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data
);
    import lcdns_pkg::*;

    t_seg_cmd   w_cmd;
    t_dp_status w_status;

    lcdns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    lcdns_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### src/lcdns_ctrl.sv
module lcdns_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  lcdns_pkg::t_dp_status  i_status,
    output lcdns_pkg::t_seg_cmd    o_cmd
);
    import lcdns_pkg::*;

    t_state     r_state, n_state;
    logic [1:0] r_idx, n_idx;
    logic [1:0] r_seg, n_seg;
    logic       w_adv;

    assign w_adv = (r_state != S_IDLE) && i_status.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_seg   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_seg   <= n_seg;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_seg   = r_seg;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.lcd_ready ? S_USER : S_PWR;
                    n_idx   = '0;
                    n_seg   = '0;
                end
            end
            S_PWR: begin
                if (w_adv) begin
                    n_state = S_WAKE;
                    n_idx   = '0;
                    n_seg   = '0;
                end
            end
            S_WAKE: begin
                if (w_adv) begin
                    if (r_seg[0]) begin
                        n_seg = '0;
                        if (r_idx == LAST_IDX) begin
                            n_state = S_INIT;
                            n_idx   = '0;
                        end else begin
                            n_idx = r_idx + 2'd1;
                        end
                    end else begin
                        n_seg = 2'd1;
                    end
                end
            end
            S_INIT: begin
                if (w_adv) begin
                    n_seg = r_seg + 2'd1;
                    if (r_seg == LAST_SEG) begin
                        if (r_idx == LAST_IDX) begin
                            n_state = S_USER;
                            n_idx   = '0;
                        end else begin
                            n_idx = r_idx + 2'd1;
                        end
                    end
                end
            end
            S_USER: begin
                if (w_adv) begin
                    n_seg = r_seg + 2'd1;
                    if (r_seg == LAST_SEG) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_cmd.load   = w_adv;
        o_cmd.idx    = r_idx;
        o_cmd.seg    = r_seg;
        o_cmd.last   = (r_state == S_USER) && (r_seg == LAST_SEG);
        unique case (r_state)
            S_PWR:   o_cmd.src = SRC_PWR;
            S_WAKE:  o_cmd.src = SRC_WAKE;
            S_INIT:  o_cmd.src = SRC_INIT;
            default: o_cmd.src = SRC_USER;
        endcase
    end

endmodule

### src/lcdns_dpath.sv
module lcdns_dpath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  lcdns_pkg::t_in_item    i_in_item,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_idx,
    input  logic [7:0]             i_cfg_data,
    input  lcdns_pkg::t_seg_cmd    i_cmd,
    output lcdns_pkg::t_dp_status  o_status,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output lcdns_pkg::t_out_item   o_out_item
);
    import lcdns_pkg::*;

    logic [7:0] r_cfg [8];
    t_in_item   r_item;
    logic       r_lcd_ready;
    logic       r_out_valid;
    t_out_item  r_out_item;
    t_out_item  w_seg;
    logic [7:0] w_byte;
    logic [7:0] w_extra;
    logic       w_rs;
    logic       w_free;

    assign w_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_POWER_UP]    <= 8'd15;
            r_cfg[CFG_ENABLE_HIGH] <= 8'd1;
            r_cfg[CFG_SETTLE]      <= 8'd1;
            r_cfg[CFG_CLEAR_WAIT]  <= 8'd2;
            r_cfg[CFG_WAKE_WAIT]   <= 8'd5;
            r_cfg[CFG_FUNC_SET]    <= 8'h28;
            r_cfg[CFG_DISPLAY]     <= 8'h0C;
            r_cfg[CFG_ENTRY_MODE]  <= 8'h06;
        end else if (i_cfg_we) begin
            r_cfg[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcd_ready <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_lcd_ready <= 1'b1;
            end
            if (i_cmd.load && w_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_item;
        end
        if (i_cmd.load && w_free) begin
            r_out_item <= w_seg;
        end
    end

    always_comb begin
        unique case (i_cmd.idx)
            2'd0:    w_byte = r_cfg[CFG_FUNC_SET];
            2'd1:    w_byte = r_cfg[CFG_DISPLAY];
            2'd2:    w_byte = r_cfg[CFG_ENTRY_MODE];
            default: w_byte = CLEAR_CMD;
        endcase
        if (i_cmd.src == SRC_USER) begin
            w_byte = r_item.byte_value;
        end
        w_rs = (i_cmd.src == SRC_USER) ? r_item.is_data : 1'b0;

        w_extra = '0;
        if (i_cmd.src == SRC_WAKE) begin
            unique case (i_cmd.idx)
                2'd0, 2'd1: w_extra = r_cfg[CFG_WAKE_WAIT];
                2'd2:       w_extra = WAKE_THIRD_MS;
                default:    w_extra = '0;
            endcase
        end else if (i_cmd.seg == LAST_SEG && !w_rs && w_byte == CLEAR_CMD) begin
            w_extra = r_cfg[CFG_CLEAR_WAIT];
        end

        w_seg.rs_level     = w_rs;
        w_seg.enable_level = ~i_cmd.seg[0];
        w_seg.last_segment = i_cmd.last;
        w_seg.duration_ms  = i_cmd.seg[0]
                           ? (10'(r_cfg[CFG_SETTLE]) + 10'(w_extra))
                           : 10'(r_cfg[CFG_ENABLE_HIGH]);
        if (i_cmd.src == SRC_WAKE) begin
            w_seg.data_nibble = (i_cmd.idx == LAST_IDX) ? WAKE_LAST_NIB : WAKE_NIBBLE;
        end else begin
            w_seg.data_nibble = i_cmd.seg[1] ? w_byte[3:0] : w_byte[7:4];
        end
        if (i_cmd.src == SRC_PWR) begin
            w_seg.rs_level     = 1'b0;
            w_seg.data_nibble  = '0;
            w_seg.enable_level = 1'b0;
            w_seg.duration_ms  = 10'(r_cfg[CFG_POWER_UP]);
        end
    end

    assign o_status.out_free  = w_free;
    assign o_status.lcd_ready = r_lcd_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_item         = r_out_item;

endmodule

### dv/char_lcd_nibble_sequencer_checker.sv
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  lcdns_pkg::t_in_item  i_in_item,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  lcdns_pkg::t_out_item i_out_item,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    output int                   o_mismatches,
    output int                   o_pending
);
    import lcdns_pkg::*;

    logic [7:0] regs [8];
    logic       woke;
    t_out_item  segs_due [$];

    task automatic push_segment(input logic rs, input logic [3:0] nib, input logic en,
                                input logic [9:0] dur, input logic last);
        t_out_item seg;
        seg.rs_level     = rs;
        seg.data_nibble  = nib;
        seg.enable_level = en;
        seg.duration_ms  = dur;
        seg.last_segment = last;
        segs_due.push_back(seg);
    endtask

    // enable-high segment, then enable-low segment carrying any extra wait
    task automatic push_strobe(input logic rs, input logic [3:0] nib, input logic [7:0] extra,
                               input logic last);
        push_segment(rs, nib, 1'b1, {2'b00, regs[CFG_ENABLE_HIGH]}, 1'b0);
        push_segment(rs, nib, 1'b0, {2'b00, regs[CFG_SETTLE]} + {2'b00, extra}, last);
    endtask

    task automatic push_byte(input logic rs, input logic [7:0] b, input logic last);
        logic [7:0] extra;
        extra = (!rs && b == CLEAR_CMD) ? regs[CFG_CLEAR_WAIT] : 8'd0;
        push_strobe(rs, b[7:4], 8'd0, 1'b0);
        push_strobe(rs, b[3:0], extra, last);
    endtask

    task automatic expand_item(input t_in_item item);
        if (!woke) begin
            push_segment(1'b0, 4'h0, 1'b0, {2'b00, regs[CFG_POWER_UP]}, 1'b0);
            push_strobe(1'b0, WAKE_NIBBLE, regs[CFG_WAKE_WAIT], 1'b0);
            push_strobe(1'b0, WAKE_NIBBLE, regs[CFG_WAKE_WAIT], 1'b0);
            push_strobe(1'b0, WAKE_NIBBLE, WAKE_THIRD_MS, 1'b0);
            push_strobe(1'b0, WAKE_LAST_NIB, 8'd0, 1'b0);
            push_byte(1'b0, regs[CFG_FUNC_SET], 1'b0);
            push_byte(1'b0, regs[CFG_DISPLAY], 1'b0);
            push_byte(1'b0, regs[CFG_ENTRY_MODE], 1'b0);
            push_byte(1'b0, CLEAR_CMD, 1'b0);
            woke = 1'b1;
        end
        push_byte(item.is_data, item.byte_value, 1'b1);
    endtask

    task automatic check_segment(input t_out_item got);
        t_out_item want;
        if (segs_due.size() == 0) begin
            o_mismatches++;
            if (o_mismatches <= 10)
                $display("unexpected segment: rs=%0d nib=%h en=%0d dur=%0d last=%0d",
                         got.rs_level, got.data_nibble, got.enable_level,
                         got.duration_ms, got.last_segment);
            return;
        end
        want = segs_due.pop_front();
        if (got.rs_level !== want.rs_level || got.data_nibble !== want.data_nibble ||
            got.enable_level !== want.enable_level || got.duration_ms !== want.duration_ms ||
            got.last_segment !== want.last_segment) begin
            o_mismatches++;
            if (o_mismatches <= 10)
                $display("segment mismatch: exp rs=%0d nib=%h en=%0d dur=%0d last=%0d,",
                         want.rs_level, want.data_nibble, want.enable_level,
                         want.duration_ms, want.last_segment,
                         " got rs=%0d nib=%h en=%0d dur=%0d last=%0d",
                         got.rs_level, got.data_nibble, got.enable_level,
                         got.duration_ms, got.last_segment);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs[CFG_POWER_UP]    = 8'd15;
            regs[CFG_ENABLE_HIGH] = 8'd1;
            regs[CFG_SETTLE]      = 8'd1;
            regs[CFG_CLEAR_WAIT]  = 8'd2;
            regs[CFG_WAKE_WAIT]   = 8'd5;
            regs[CFG_FUNC_SET]    = 8'h28;
            regs[CFG_DISPLAY]     = 8'h0C;
            regs[CFG_ENTRY_MODE]  = 8'h06;
            woke = 1'b0;
            segs_due.delete();
        end else begin
            if (i_cfg_we)
                regs[i_cfg_idx] = i_cfg_data;
            if (i_in_valid && i_in_ready)
                expand_item(i_in_item);
            if (i_out_valid && i_out_ready)
                check_segment(i_out_item);
        end
        o_pending = segs_due.size();
    end

endmodule

### dv/char_lcd_nibble_sequencer_test.sv
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_test;
    import lcdns_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 60;

    localparam logic [7:0][7:0] REG_DEFAULTS =
        {8'h06, 8'h0C, 8'h28, 8'd5, 8'd2, 8'd1, 8'd1, 8'd15};

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    t_in_item   in_item   = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    t_out_item  out_item;
    logic       cfg_we    = 1'b0;
    logic [2:0] cfg_idx   = '0;
    logic [7:0] cfg_data  = '0;
    int         mismatches;
    int         pending;
    int         cycles    = 0;
    bit         calm      = 1'b0;

    char_lcd_nibble_sequencer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    char_lcd_nibble_sequencer_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_gap(input bit quiet);
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        if ($urandom_range(0, 99) < 15)
            return CLEAR_CMD;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0][7:0] rand_regs(input int hi);
        logic [7:0][7:0] vals;
        for (int i = 0; i < 8; i++)
            vals[i] = 8'($urandom_range(0, hi));
        return vals;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic load_regs(input logic [7:0][7:0] vals);
        for (int i = 0; i < 8; i++)
            write_reg(3'(i), vals[i]);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_byte(input logic is_data, input logic [7:0] value);
        int gap;
        gap = pick_gap(calm);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{is_data: is_data, byte_value: value};
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // output back-pressure: short runs and stalls, now and then a long free run
    initial begin : out_stall
        int run_len;
        int stall;
        @(negedge clk);
        forever begin
            out_ready <= 1'b1;
            run_len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 12);
            repeat (run_len) @(negedge clk);
            stall = pick_gap(1'b0);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    initial begin : stimulus
        logic [7:0][7:0] setting;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // wake-up runs once per reset, so pick its timing per seed
        case ($urandom_range(0, 2))
            1: begin
                setting = {8{8'hFF}};
                setting[CFG_FUNC_SET] = CLEAR_CMD;
            end
            2: begin
                setting = '0;
                setting[CFG_CLEAR_WAIT] = 8'hFF;
                setting[CFG_DISPLAY]    = CLEAR_CMD;
            end
            default: setting = REG_DEFAULTS;
        endcase
        load_regs(setting);

        send_byte(1'b0, CLEAR_CMD);
        send_byte(1'b1, CLEAR_CMD);
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b1, 8'h00);
        send_byte(1'b1, 8'hFF);
        send_byte(1'b0, 8'h10);
        send_byte(1'b1, 8'hA5);
        send_byte(1'b0, 8'h5A);
        send_byte(1'b1, 8'h0F);
        drain();

        load_regs({8{8'hFF}});
        send_byte(1'b0, CLEAR_CMD);
        send_byte(1'b1, CLEAR_CMD);
        send_byte(1'b0, 8'h80);
        send_byte(1'b1, 8'h7F);
        drain();

        load_regs('0);
        send_byte(1'b0, CLEAR_CMD);
        send_byte(1'b1, 8'hC3);
        send_byte(1'b0, 8'h3C);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 3)
                0:       load_regs(rand_regs(255));
                1:       load_regs(rand_regs(3));
                default: load_regs(REG_DEFAULTS);
            endcase
            calm = (ph == 4);
            repeat (PHASE_ITEMS)
                send_byte($urandom_range(0, 1) == 1, rand_byte());
            drain();
        end
        calm = 1'b0;

        repeat (32) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
